>>> rtl/per_origin_window_rate_limiter_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the per-origin rate limiter
// Implication checks on the clock clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PER_ORIGIN_WINDOW_RATE_LIMITER_CORE_MACROS_SVH
`define PER_ORIGIN_WINDOW_RATE_LIMITER_CORE_MACROS_SVH

// Same-cycle implication.
`define POWRL_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rate limiter check failed");

// Next-cycle implication.
`define POWRL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rate limiter check failed");

`endif

>>> rtl/powrl_pkg.sv
// ----------------------------------------------------------------------------
// Rate limiter package
// Shared widths, codes, defaults and the sequencer state type.
// ----------------------------------------------------------------------------
package powrl_pkg;

	localparam int unsigned MAX_ORIGINS_DEF = 16;
	localparam int unsigned KEY_BITS_DEF    = 64;
	localparam int unsigned KEY_PORT_W      = 64;
	localparam int unsigned TICK_W          = 32;
	localparam int unsigned CFG_IDX_W       = 8;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ATTEMPT_LIMIT = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		STATUS_ALLOWED    = 2'd0,
		STATUS_OVER_LIMIT = 2'd1,
		STATUS_TABLE_FULL = 2'd2,
		STATUS_ZERO_CFG   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_ELAPSED,
		ST_WINDOW,
		ST_LIMIT,
		ST_RETRY,
		ST_INC,
		ST_WRITE,
		ST_DONE
	} state_t;

endpackage

>>> rtl/powrl_alu.sv
// ----------------------------------------------------------------------------
// Shared subtract and compare unit
// Gives a minus b modulo 2^32 and whether a is at least b.
// ----------------------------------------------------------------------------
module powrl_alu (
	input  logic [powrl_pkg::TICK_W-1:0] a,
	input  logic [powrl_pkg::TICK_W-1:0] b,
	output logic [powrl_pkg::TICK_W-1:0] diff,
	output logic                         ge
);

	logic [powrl_pkg::TICK_W:0] full;

	assign full = {1'b0, a} - {1'b0, b};
	assign diff = full[powrl_pkg::TICK_W-1:0];
	assign ge   = ~full[powrl_pkg::TICK_W];

endmodule

>>> rtl/powrl_table.sv
// ----------------------------------------------------------------------------
// Origin table
// Entry memory with one registered read port and one write port, plus a
// valid flag per entry that reset clears.
// ----------------------------------------------------------------------------
module powrl_table #(
	parameter int unsigned MAX_ORIGINS = powrl_pkg::MAX_ORIGINS_DEF,
	parameter int unsigned KEY_BITS    = powrl_pkg::KEY_BITS_DEF,
	localparam int unsigned IDX_W      = (MAX_ORIGINS > 1) ? $clog2(MAX_ORIGINS) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [IDX_W-1:0]             rd_addr,
	output logic [KEY_BITS-1:0]          rd_key,
	output logic [powrl_pkg::TICK_W-1:0] rd_start,
	output logic [powrl_pkg::TICK_W-1:0] rd_att,
	input  logic                         wr_en,
	input  logic [IDX_W-1:0]             wr_addr,
	input  logic [KEY_BITS-1:0]          wr_key,
	input  logic [powrl_pkg::TICK_W-1:0] wr_start,
	input  logic [powrl_pkg::TICK_W-1:0] wr_att,
	output logic [MAX_ORIGINS-1:0]       valid
);

	localparam int unsigned WORD_W = KEY_BITS + 2 * powrl_pkg::TICK_W;

	logic [WORD_W-1:0]      mem_q [MAX_ORIGINS];
	logic [WORD_W-1:0]      rd_word_q;
	logic [MAX_ORIGINS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= {wr_key, wr_start, wr_att};
		end
		if (rd_en) begin
			rd_word_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_key   = rd_word_q[WORD_W-1 -: KEY_BITS];
	assign rd_start = rd_word_q[2*powrl_pkg::TICK_W-1 -: powrl_pkg::TICK_W];
	assign rd_att   = rd_word_q[powrl_pkg::TICK_W-1:0];
	assign valid    = valid_q;

endmodule

>>> rtl/per_origin_window_rate_limiter_core.sv
// ----------------------------------------------------------------------------
// Per-origin fixed-window rate limiter
// Looks up or claims an origin entry, then counts the request against that
// origin's window with one shared subtract and compare unit.
//
//   Channel | Handshake          | Carries
//   in      | in_valid/in_stall  | origin_key, cur_tick
//   out     | out_valid/out_stall| allowed, retry_after, status
//   cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// The table walk reads one entry per cycle over the read port; a zero
// configuration skips the walk, and a hit ends the walk early.
// The next request is taken once the result sits in the output register.
// Reset clears the valid flags at once; there is no clearing pass.
// A stalled result holds the sequencer until it is taken.
// ----------------------------------------------------------------------------
`include "per_origin_window_rate_limiter_core_macros.svh"

module per_origin_window_rate_limiter_core #(
	parameter int unsigned MAX_ORIGINS = powrl_pkg::MAX_ORIGINS_DEF,
	parameter int unsigned KEY_BITS    = powrl_pkg::KEY_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [powrl_pkg::KEY_PORT_W-1:0] origin_key,
	input  logic [powrl_pkg::TICK_W-1:0]    cur_tick,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            allowed,
	output logic [powrl_pkg::TICK_W-1:0]    retry_after,
	output logic [1:0]                      status,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [powrl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [powrl_pkg::TICK_W-1:0]    cfg_data
);

	localparam int unsigned IDX_W = (MAX_ORIGINS > 1) ? $clog2(MAX_ORIGINS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ORIGINS - 1);
	localparam int unsigned TW = powrl_pkg::TICK_W;

	powrl_pkg::state_t  state_q, state_d;
	powrl_pkg::status_t res_status_q, status_q;

	logic [TW-1:0]       window_q, limit_q;
	logic [KEY_BITS-1:0] key_q;
	logic [TW-1:0]       now_q, start_q, att_q, elap_q, res_retry_q, retry_q;
	logic                res_allow_q, allowed_q, out_valid_q;
	logic [IDX_W-1:0]    issue_addr_q, rd_idx_s1, free_idx_q, ent_idx_q, free_pick;
	logic                issue_more_q, rd_vld_s1, free_seen_q;

	logic [KEY_BITS-1:0]    rd_key;
	logic [TW-1:0]          rd_start, rd_att;
	logic [MAX_ORIGINS-1:0] valid;
	logic                   rd_en, wr_en, out_load;
	logic [TW-1:0]          alu_a, alu_b, alu_diff;
	logic                   alu_ge;
	logic                   scan_hit, scan_free, scan_end, scan_free_any, cfg_zero;

	powrl_table #(
		.MAX_ORIGINS(MAX_ORIGINS),
		.KEY_BITS   (KEY_BITS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (issue_addr_q),
		.rd_key  (rd_key),
		.rd_start(rd_start),
		.rd_att  (rd_att),
		.wr_en   (wr_en),
		.wr_addr (ent_idx_q),
		.wr_key  (key_q),
		.wr_start(start_q),
		.wr_att  (att_q),
		.valid   (valid)
	);

	powrl_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.diff(alu_diff),
		.ge  (alu_ge)
	);

	assign cfg_zero      = (window_q == '0) || (limit_q == '0);
	assign scan_hit      = rd_vld_s1 && valid[rd_idx_s1] && (rd_key == key_q);
	assign scan_free     = rd_vld_s1 && !valid[rd_idx_s1];
	assign scan_end      = rd_vld_s1 && (rd_idx_s1 == LAST_IDX);
	assign scan_free_any = free_seen_q || scan_free;
	assign free_pick     = free_seen_q ? free_idx_q : rd_idx_s1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			powrl_pkg::ST_IDLE: begin
				if (in_valid) state_d = powrl_pkg::ST_CHECK;
			end
			powrl_pkg::ST_CHECK: begin
				state_d = cfg_zero ? powrl_pkg::ST_DONE : powrl_pkg::ST_SCAN;
			end
			powrl_pkg::ST_SCAN: begin
				if (scan_hit) begin
					state_d = powrl_pkg::ST_ELAPSED;
				end else if (scan_end) begin
					state_d = scan_free_any ? powrl_pkg::ST_WRITE : powrl_pkg::ST_DONE;
				end
			end
			powrl_pkg::ST_ELAPSED: state_d = powrl_pkg::ST_WINDOW;
			powrl_pkg::ST_WINDOW: begin
				state_d = alu_ge ? powrl_pkg::ST_WRITE : powrl_pkg::ST_LIMIT;
			end
			powrl_pkg::ST_LIMIT: begin
				state_d = alu_ge ? powrl_pkg::ST_RETRY : powrl_pkg::ST_INC;
			end
			powrl_pkg::ST_RETRY: state_d = powrl_pkg::ST_DONE;
			powrl_pkg::ST_INC:   state_d = powrl_pkg::ST_WRITE;
			powrl_pkg::ST_WRITE: state_d = powrl_pkg::ST_DONE;
			powrl_pkg::ST_DONE: begin
				if (out_load) state_d = powrl_pkg::ST_IDLE;
			end
			default: state_d = powrl_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != powrl_pkg::ST_IDLE);
		rd_en    = (state_q == powrl_pkg::ST_SCAN) && issue_more_q;
		wr_en    = (state_q == powrl_pkg::ST_WRITE);
		out_load = (state_q == powrl_pkg::ST_DONE) && (!out_valid_q || !out_stall);
		alu_a    = now_q;
		alu_b    = start_q;
		case (state_q)
			powrl_pkg::ST_WINDOW: begin
				alu_a = elap_q;
				alu_b = window_q;
			end
			powrl_pkg::ST_LIMIT: begin
				alu_a = att_q;
				alu_b = limit_q;
			end
			powrl_pkg::ST_RETRY: begin
				alu_a = window_q;
				alu_b = elap_q;
			end
			powrl_pkg::ST_INC: begin
				// Subtracting all ones adds one.
				alu_a = att_q;
				alu_b = '1;
			end
			default: begin
				alu_a = now_q;
				alu_b = start_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= powrl_pkg::ST_IDLE;
			out_valid_q  <= 1'b0;
			issue_more_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			free_seen_q  <= 1'b0;
			window_q     <= '0;
			limit_q      <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == powrl_pkg::REG_WINDOW_LENGTH) window_q <= cfg_data;
				if (cfg_index == powrl_pkg::REG_ATTEMPT_LIMIT) limit_q  <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == powrl_pkg::ST_CHECK) begin
				issue_more_q <= 1'b1;
				free_seen_q  <= 1'b0;
			end else if (state_q == powrl_pkg::ST_SCAN) begin
				if (rd_en && (issue_addr_q == LAST_IDX)) issue_more_q <= 1'b0;
				if (scan_free) free_seen_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			powrl_pkg::ST_IDLE: begin
				if (in_valid) begin
					key_q <= origin_key[KEY_BITS-1:0];
					now_q <= cur_tick;
				end
			end
			powrl_pkg::ST_CHECK: begin
				issue_addr_q <= '0;
				res_allow_q  <= 1'b0;
				res_retry_q  <= '0;
				res_status_q <= powrl_pkg::STATUS_ZERO_CFG;
			end
			powrl_pkg::ST_SCAN: begin
				if (rd_en) issue_addr_q <= issue_addr_q + 1'b1;
				if (scan_free && !free_seen_q) free_idx_q <= rd_idx_s1;
				if (scan_hit) begin
					ent_idx_q <= rd_idx_s1;
					start_q   <= rd_start;
					att_q     <= rd_att;
				end else if (scan_end) begin
					if (scan_free_any) begin
						ent_idx_q    <= free_pick;
						start_q      <= now_q;
						att_q        <= TW'(1);
						res_allow_q  <= 1'b1;
						res_status_q <= powrl_pkg::STATUS_ALLOWED;
					end else begin
						res_status_q <= powrl_pkg::STATUS_TABLE_FULL;
					end
				end
			end
			powrl_pkg::ST_ELAPSED: elap_q <= alu_diff;
			powrl_pkg::ST_WINDOW: begin
				if (alu_ge) begin
					start_q      <= now_q;
					att_q        <= TW'(1);
					res_allow_q  <= 1'b1;
					res_status_q <= powrl_pkg::STATUS_ALLOWED;
				end
			end
			powrl_pkg::ST_RETRY: begin
				res_retry_q  <= alu_diff;
				res_status_q <= powrl_pkg::STATUS_OVER_LIMIT;
			end
			powrl_pkg::ST_INC: begin
				att_q        <= alu_diff;
				res_allow_q  <= 1'b1;
				res_status_q <= powrl_pkg::STATUS_ALLOWED;
			end
			powrl_pkg::ST_DONE: begin
				if (out_load) begin
					allowed_q <= res_allow_q;
					retry_q   <= res_retry_q;
					status_q  <= res_status_q;
				end
			end
			default: begin
			end
		endcase
		rd_idx_s1 <= issue_addr_q;
	end

	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign allowed     = allowed_q;
	assign retry_after = retry_q;
	assign status      = status_q;

	`POWRL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`POWRL_ASSERT_IMPL(a_write_needs_cfg, wr_en, (window_q != '0) && (limit_q != '0))
	`POWRL_ASSERT_IMPL(a_allowed_status, out_valid && allowed,
		(status_q == powrl_pkg::STATUS_ALLOWED) && (retry_after == '0))
	`POWRL_ASSERT_IMPL(a_over_limit_retry,
		out_valid && (status_q == powrl_pkg::STATUS_OVER_LIMIT), retry_after != '0)

endmodule
